// ----- rtl/go_to_goal_steering_controller_defines.svh -----
// Assertion macros shared by the steering controller RTL.
`ifndef GO_TO_GOAL_STEERING_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_STEERING_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define G2G_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define G2G_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define G2G_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define G2G_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/g2g_pkg.sv -----
// Widths, constants and the arctangent table of the steering controller.
package g2g_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int POS_W  = 16;
   localparam int HDG_W  = 15;
   localparam int TGT_W  = 15;
   localparam int DIFF_W = 18;
   localparam int XY_W   = 35;
   localparam int Z_W    = 21;
   localparam int ERR_W  = 21;
   localparam int DIST_W = 33;
   localparam int MB_W   = 18;
   localparam int PROD_W = XY_W + MB_W;
   localparam int LIN_W  = 15;
   localparam int ANG_W  = 16;

   localparam logic OP_POSE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic REG_TARGET_X = 1'b0;
   localparam logic REG_TARGET_Y = 1'b1;

   localparam logic [TGT_W-1:0] TARGET_X_RESET = 15'd2048;
   localparam logic [TGT_W-1:0] TARGET_Y_RESET = 15'd4096;

   localparam logic signed [Z_W-1:0] PI_Z = 21'sd205887;
   localparam logic signed [ERR_W:0] PI_E = 22'sd205887;
   localparam logic signed [ERR_W:0] TWO_PI_E = 22'sd411775;
   localparam logic signed [MB_W-1:0] GAIN_INV = 18'sd39797;
   localparam logic signed [MB_W-1:0] K_SLOW = 18'sd13107;
   localparam logic signed [MB_W-1:0] K_FAST = 18'sd58982;
   localparam logic signed [MB_W-1:0] K_TURN = 18'sd117965;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 33'sd3355443;
   localparam logic signed [ERR_W-1:0] ERR_MIN = 21'sd6553;
   localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sd23163;
   localparam logic [LIN_W-1:0] LIN_MAX = 15'd32767;

   function automatic logic [15:0] atan_q16(input logic [4:0] idx);
      logic [15:0] a;
      unique case (idx)
         5'd0:  a = 16'd51472;
         5'd1:  a = 16'd30386;
         5'd2:  a = 16'd16055;
         5'd3:  a = 16'd8150;
         5'd4:  a = 16'd4091;
         5'd5:  a = 16'd2047;
         5'd6:  a = 16'd1024;
         5'd7:  a = 16'd512;
         5'd8:  a = 16'd256;
         5'd9:  a = 16'd128;
         5'd10: a = 16'd64;
         5'd11: a = 16'd32;
         5'd12: a = 16'd16;
         5'd13: a = 16'd8;
         5'd14: a = 16'd4;
         5'd15: a = 16'd2;
         5'd16: a = 16'd1;
         default: a = 16'd0;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/g2g_mul.sv -----
// Shared signed multiplier with a registered product.
module g2g_mul (
   input  logic                               clock,
   input  logic signed [g2g_pkg::XY_W-1:0]    mul_a,
   input  logic signed [g2g_pkg::MB_W-1:0]    mul_b,
   output logic signed [g2g_pkg::PROD_W-1:0]  prod
);
   import g2g_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ----- rtl/g2g_cordic.sv -----
// Iterative vectoring CORDIC giving the scaled range and the bearing to the goal.
module g2g_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [g2g_pkg::DIFF_W-1:0] dx,
   input  logic signed [g2g_pkg::DIFF_W-1:0] dy,
   output logic                              done,
   output logic signed [g2g_pkg::XY_W-1:0]   x_out,
   output logic signed [g2g_pkg::Z_W-1:0]    z_out
);
   import g2g_pkg::*;

   localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic signed [XY_W-1:0] x0, y0, xs, ys;
   logic signed [Z_W-1:0]  at;

   assign x0 = {{(XY_W-DIFF_W){dx[DIFF_W-1]}}, dx} <<< 14;
   assign y0 = {{(XY_W-DIFF_W){dy[DIFF_W-1]}}, dy} <<< 14;
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = signed'({{(Z_W-16){1'b0}}, atan_q16(5'(cnt_ff))});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         if (x0 < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (y0 >= 0) ? PI_Z : -PI_Z;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (!y_ff[XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;
endmodule

// ----- rtl/go_to_goal_steering_controller.sv -----
// Go-to-goal steering controller top level: registers, sequencer and output stage.
// A pose update (req_tuser low) is stored in the cycle it is accepted and gives no item.
// A control tick (req_tuser high) with a stored pose runs a vectoring CORDIC of
// CORDIC_STEPS iterations, one per cycle, then steps through ST_ERR, ST_DIST, ST_MULL,
// ST_LIN and ST_ANG on a single shared multiplier for gain removal, speed gain and turn
// gain, and loads the output register in ST_DONE, which waits while an earlier result is
// not yet taken; the input is then ready for the next item. A tick before any pose is
// dropped at once. The input is not ready while a tick is worked on, but is ready again
// while the result still waits in the output register.
// Targets are written through the register port at byte addresses 0 (x) and 4 (y).
`include "go_to_goal_steering_controller_defines.svh"
module go_to_goal_steering_controller #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pose_x [15:0], pose_y [31:16], pose_heading [46:32], zero [47]
   input  logic [g2g_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // linear_speed [14:0], angular_speed [30:15], zero [31]
   output logic [g2g_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [g2g_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [g2g_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [g2g_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import g2g_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CORDIC = 8'b0000_0010,
      ST_ERR    = 8'b0000_0100,
      ST_DIST   = 8'b0000_1000,
      ST_MULL   = 8'b0001_0000,
      ST_LIN    = 8'b0010_0000,
      ST_ANG    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [TGT_W-1:0]         target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic                     pose_valid_ff, pose_valid_in;
   logic signed [POS_W-1:0]  last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [HDG_W-1:0]  last_heading_ff, last_heading_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [DIST_W-1:0] dist_ff, dist_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in, rsp_ang_ff, rsp_ang_in;
   logic [LIN_W-1:0]         lin_ff, lin_in, rsp_lin_ff, rsp_lin_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     req_acc, is_tick, csr_wr, cordic_start, cordic_done;
   logic                     near, turn;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [XY_W-1:0]   cx;
   logic signed [Z_W-1:0]    cz;
   logic signed [XY_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ERR_W:0]    err_raw, err_wrap;
   logic signed [PROD_W-1:0] lin_sum, ang_sum;
   logic signed [PROD_W-31:0] lin_full;
   logic signed [PROD_W-21:0] ang_p, ang_e_sum, ang_full;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_tick    = (req_tuser == OP_TICK);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TARGET_Y) ? {{(CSR_DATA_W-TGT_W){1'b0}}, target_y_ff}
                                                      : {{(CSR_DATA_W-TGT_W){1'b0}}, target_x_ff};

   assign dx = signed'({3'b000, target_x_ff}) - DIFF_W'(last_x_ff);
   assign dy = signed'({3'b000, target_y_ff}) - DIFF_W'(last_y_ff);

   g2g_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx),
      .dy    (dy),
      .done  (cordic_done),
      .x_out (cx),
      .z_out (cz)
   );

   g2g_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign err_raw  = {cz[Z_W-1], cz} - {{3{last_heading_ff[HDG_W-1]}}, last_heading_ff, 4'b0000};
   assign err_wrap = (err_raw > PI_E) ? err_raw - TWO_PI_E :
                     (err_raw < -PI_E) ? err_raw + TWO_PI_E : err_raw;

   assign near = (dist_ff <= DIST_MIN);
   assign turn = (err_ff > ERR_MIN) || (err_ff < -ERR_MIN);

   assign lin_sum   = prod + PROD_W'(64'sd536870912);
   assign lin_full  = signed'(lin_sum[PROD_W-1:30]);
   assign ang_sum   = prod + PROD_W'(64'sd524288);
   assign ang_p     = signed'(ang_sum[PROD_W-1:20]);
   assign ang_e_sum = (PROD_W-20)'(err_ff) + (PROD_W-20)'(64'sd8);
   assign ang_full  = turn ? ang_p : (ang_e_sum >>> 4);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ERR: begin
            mul_a = cx;
            mul_b = GAIN_INV;
         end
         ST_MULL: begin
            mul_a = XY_W'(dist_ff);
            mul_b = turn ? K_SLOW : K_FAST;
         end
         ST_LIN: begin
            mul_a = XY_W'(err_ff);
            mul_b = K_TURN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      target_x_in     = target_x_ff;
      target_y_in     = target_y_ff;
      pose_valid_in   = pose_valid_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      last_heading_in = last_heading_ff;
      err_in          = err_ff;
      dist_in         = dist_ff;
      lin_in          = lin_ff;
      ang_in          = ang_ff;
      rsp_lin_in      = rsp_lin_ff;
      rsp_ang_in      = rsp_ang_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      cordic_start    = 1'b0;

      if (csr_wr) begin
         if (csr_paddr[2] == REG_TARGET_Y) begin
            target_y_in = csr_pwdata[TGT_W-1:0];
         end else begin
            target_x_in = csr_pwdata[TGT_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!is_tick) begin
                  last_x_in       = signed'(req_tdata[15:0]);
                  last_y_in       = signed'(req_tdata[31:16]);
                  last_heading_in = signed'(req_tdata[46:32]);
                  pose_valid_in   = 1'b1;
               end else if (pose_valid_ff) begin
                  cordic_start = 1'b1;
                  state_in     = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = ERR_W'(err_wrap);
            state_in = ST_DIST;
         end
         ST_DIST: begin
            dist_in  = DIST_W'(prod >>> 16);
            state_in = ST_MULL;
         end
         ST_MULL: begin
            state_in = ST_LIN;
         end
         ST_LIN: begin
            if (lin_full > signed'((PROD_W-30)'(LIN_MAX))) begin
               lin_in = LIN_MAX;
            end else if (lin_full < 0) begin
               lin_in = '0;
            end else begin
               lin_in = LIN_W'(lin_full);
            end
            state_in = ST_ANG;
         end
         ST_ANG: begin
            if (near) begin
               lin_in = '0;
               ang_in = '0;
            end else if (ang_full > (PROD_W-20)'(ANG_MAX)) begin
               ang_in = ANG_MAX;
            end else if (ang_full < -(PROD_W-20)'(ANG_MAX)) begin
               ang_in = -ANG_MAX;
            end else begin
               ang_in = ANG_W'(ang_full);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_lin_in   = lin_ff;
               rsp_ang_in   = ang_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_x_ff   <= TARGET_X_RESET;
         target_y_ff   <= TARGET_Y_RESET;
         pose_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         pose_valid_ff <= pose_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_x_ff       <= last_x_in;
      last_y_ff       <= last_y_in;
      last_heading_ff <= last_heading_in;
      err_ff          <= err_in;
      dist_ff         <= dist_in;
      lin_ff          <= lin_in;
      ang_ff          <= ang_in;
      rsp_lin_ff      <= rsp_lin_in;
      rsp_ang_ff      <= rsp_ang_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ang_ff, rsp_lin_ff};

   `G2G_ASSERT_IMPL(a_ang_range, clock, reset, rsp_valid_ff, (rsp_ang_ff <= ANG_MAX) && (rsp_ang_ff >= -ANG_MAX), "Angular command outside its saturation range")
   `G2G_ASSERT_NEXT(a_tick_no_pose, clock, reset, req_acc && is_tick && !pose_valid_ff, state_ff == ST_IDLE, "Tick without a pose started a computation")
   `G2G_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_tready, (state_ff == ST_DONE) && $stable(rsp_lin_ff) && $stable(rsp_ang_ff), "Result overwrote an item not yet taken")
   `G2G_ASSERT_IMPL(a_near_zero, clock, reset, (state_ff == ST_DONE) && near, (lin_ff == '0) && (ang_ff == '0), "Commands not zero close to the goal")
endmodule
